// ----- design/cpsp_pkg.sv -----
`default_nettype none

package cpsp_pkg;

  localparam int unsigned CPSP_NUM_TAGS_DEF = 16;
  localparam int unsigned CPSP_HDR_SHIFT    = 3;   // eight header bytes per entry

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;
  localparam logic [1:0] ST_BADTAG   = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] section_size;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] entry_number;
    logic [7:0]  entry_tag;
    logic [31:0] entry_length;
    logic [31:0] payload_offset;
    logic        final_res;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

// ----- design/cpsp_in_stage.sv -----
`default_nettype none

module cpsp_in_stage
  import cpsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     take,
  output logic          item_valid,
  output in_item_t      item
);

  logic     valid_r;
  in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- design/cpsp_core.sv -----
`default_nettype none

module cpsp_core
  import cpsp_pkg::*;
#(
  parameter int unsigned NUM_TAGS = CPSP_NUM_TAGS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire in_item_t item,
  output logic          res_valid,
  output res_t          res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_COUNT   = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_PAD     = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  localparam logic [8:0] TAG_LIMIT = 9'(NUM_TAGS);

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] position_r, position_nxt;
  logic [31:0] remain_r, remain_nxt;      // size_held - position
  logic [31:0] size_held_r, size_held_nxt;
  logic [31:0] entries_left_r, entries_left_nxt;
  logic [31:0] entry_counter_r, entry_counter_nxt;
  logic [31:0] field_r, field_nxt;
  logic [1:0]  byte_in_field_r, byte_in_field_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] payload_left_r, payload_left_nxt;
  logic [31:0] payload_start_r, payload_start_nxt;

  logic [7:0]  b;
  logic [1:0]  k;
  logic [31:0] assembled;
  logic [31:0] pos_inc;
  logic [31:0] rem_dec;
  logic [31:0] pl_dec;
  logic [31:0] count_limit;
  logic [1:0]  pad;
  logic        do_finish;
  logic [31:0] fin_length;
  logic [31:0] fin_start;
  logic        fin_end;
  logic [1:0]  fin_status;

  assign b           = item.data_byte;
  assign k           = byte_in_field_r;
  assign assembled   = field_r | (32'(b) << {k, 3'b000});
  assign pos_inc     = position_r + 32'd1;
  assign rem_dec     = remain_r - 32'd1;
  assign pl_dec      = payload_left_r - 32'd1;
  assign count_limit = (size_held_r - 32'd4) >> CPSP_HDR_SHIFT;

  always_comb begin
    phase_nxt         = phase_r;
    position_nxt      = position_r;
    remain_nxt        = remain_r;
    size_held_nxt     = size_held_r;
    entries_left_nxt  = entries_left_r;
    entry_counter_nxt = entry_counter_r;
    field_nxt         = field_r;
    byte_in_field_nxt = byte_in_field_r;
    tag_nxt           = tag_r;
    payload_left_nxt  = payload_left_r;
    payload_start_nxt = payload_start_r;
    res_valid         = 1'b0;
    res               = '0;
    do_finish         = 1'b0;
    fin_length        = field_r;
    fin_start         = payload_start_r;
    fin_end           = 1'b0;
    fin_status        = ST_OK;
    pad               = 2'd0;

    if (step_en) begin
      if (item.opcode == OP_START) begin
        position_nxt      = '0;
        remain_nxt        = item.section_size;
        size_held_nxt     = item.section_size;
        entries_left_nxt  = '0;
        entry_counter_nxt = '0;
        field_nxt         = '0;
        byte_in_field_nxt = '0;
        tag_nxt           = '0;
        payload_left_nxt  = '0;
        payload_start_nxt = '0;
        if (item.section_size < 32'd4) begin
          phase_nxt     = PH_DONE;
          res_valid     = 1'b1;
          res.final_res = 1'b1;
          res.status    = ST_TRUNC;
        end else begin
          phase_nxt = PH_COUNT;
        end
      end else begin
        unique case (phase_r)
          PH_COUNT: begin
            field_nxt         = assembled;
            position_nxt      = pos_inc;
            remain_nxt        = rem_dec;
            byte_in_field_nxt = 2'(k + 2'd1);
            if (k == 2'd3) begin
              if (assembled == 32'd0) begin
                phase_nxt     = PH_DONE;
                res_valid     = 1'b1;
                res.final_res = 1'b1;
                res.status    = ST_OK;
              end else if (assembled > count_limit) begin
                phase_nxt     = PH_DONE;
                res_valid     = 1'b1;
                res.final_res = 1'b1;
                res.status    = ST_TRUNC;
              end else begin
                entries_left_nxt = assembled;
                field_nxt        = '0;
                phase_nxt        = PH_HEADER;
              end
            end
          end
          PH_HEADER: begin
            position_nxt      = pos_inc;
            remain_nxt        = rem_dec;
            byte_in_field_nxt = 2'(k + 2'd1);
            if (k == 2'd0) begin
              tag_nxt = b;
            end else if (b != 8'd0) begin
              phase_nxt     = PH_DONE;
              res_valid     = 1'b1;
              res.final_res = 1'b1;
              res.status    = ST_RESERVED;
            end else if (k == 2'd3) begin
              if ({1'b0, tag_r} >= TAG_LIMIT) begin
                phase_nxt     = PH_DONE;
                res_valid     = 1'b1;
                res.final_res = 1'b1;
                res.status    = ST_BADTAG;
              end else if (rem_dec < 32'd4) begin
                phase_nxt     = PH_DONE;
                res_valid     = 1'b1;
                res.final_res = 1'b1;
                res.status    = ST_TRUNC;
              end else begin
                field_nxt = '0;
                phase_nxt = PH_LENGTH;
              end
            end
          end
          PH_LENGTH: begin
            field_nxt         = assembled;
            position_nxt      = pos_inc;
            remain_nxt        = rem_dec;
            byte_in_field_nxt = 2'(k + 2'd1);
            // pad bytes needed after the payload to reach a 4-byte offset
            pad = 2'(2'd0 - (pos_inc[1:0] + assembled[1:0]));
            if (k == 2'd3) begin
              if (assembled > rem_dec) begin
                phase_nxt     = PH_DONE;
                res_valid     = 1'b1;
                res.final_res = 1'b1;
                res.status    = ST_TRUNC;
              end else if (32'(pad) > (rem_dec - assembled)) begin
                phase_nxt     = PH_DONE;
                res_valid     = 1'b1;
                res.final_res = 1'b1;
                res.status    = ST_TRUNC;
              end else begin
                payload_start_nxt = pos_inc;
                if (assembled == 32'd0) begin
                  do_finish  = 1'b1;
                  fin_length = assembled;
                  fin_start  = pos_inc;
                end else begin
                  payload_left_nxt = assembled;
                  phase_nxt        = PH_PAYLOAD;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            position_nxt     = pos_inc;
            remain_nxt       = rem_dec;
            payload_left_nxt = pl_dec;
            pad              = 2'(2'd0 - pos_inc[1:0]);
            if (pl_dec == 32'd0) begin
              if (pad == 2'd0) begin
                do_finish = 1'b1;
              end else begin
                payload_left_nxt = 32'(pad);
                phase_nxt        = PH_PAD;
              end
            end
          end
          PH_PAD: begin
            position_nxt = pos_inc;
            remain_nxt   = rem_dec;
            if (b != 8'd0) begin
              phase_nxt     = PH_DONE;
              res_valid     = 1'b1;
              res.final_res = 1'b1;
              res.status    = ST_RESERVED;
            end else begin
              payload_left_nxt = pl_dec;
              if (pl_dec == 32'd0) begin
                do_finish = 1'b1;
              end
            end
          end
          default: begin
            // idle or done: drop the byte
          end
        endcase
      end

      if (do_finish) begin
        if (entries_left_r <= 32'd1) begin
          fin_end = 1'b1;
        end else if (rem_dec < 32'd4) begin
          fin_end    = 1'b1;
          fin_status = ST_TRUNC;
        end
        res_valid          = 1'b1;
        res.entry_valid    = 1'b1;
        res.entry_number   = entry_counter_r;
        res.entry_tag      = tag_r;
        res.entry_length   = fin_length;
        res.payload_offset = fin_start;
        res.final_res      = fin_end;
        res.status         = fin_end ? fin_status : ST_OK;
        entry_counter_nxt  = entry_counter_r + 32'd1;
        entries_left_nxt   = entries_left_r - 32'd1;
        byte_in_field_nxt  = '0;
        phase_nxt          = fin_end ? PH_DONE : PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      position_r      <= '0;
      remain_r        <= '0;
      size_held_r     <= '0;
      entries_left_r  <= '0;
      entry_counter_r <= '0;
      field_r         <= '0;
      byte_in_field_r <= '0;
      tag_r           <= '0;
      payload_left_r  <= '0;
      payload_start_r <= '0;
    end else begin
      phase_r         <= phase_nxt;
      position_r      <= position_nxt;
      remain_r        <= remain_nxt;
      size_held_r     <= size_held_nxt;
      entries_left_r  <= entries_left_nxt;
      entry_counter_r <= entry_counter_nxt;
      field_r         <= field_nxt;
      byte_in_field_r <= byte_in_field_nxt;
      tag_r           <= tag_nxt;
      payload_left_r  <= payload_left_nxt;
      payload_start_r <= payload_start_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_remain_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (position_r + remain_r) == size_held_r)
    else $error("remaining byte count out of step with position");

  a_entries_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HEADER || phase_r == PH_LENGTH || phase_r == PH_PAYLOAD ||
     phase_r == PH_PAD) |-> entries_left_r != 32'd0)
    else $error("entry phase with no entries left");

  a_payload_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD || phase_r == PH_PAD) |-> payload_left_r != 32'd0)
    else $error("payload or pad phase with nothing left");
`endif

endmodule

`default_nettype wire

// ----- design/cpsp_out_buf.sv -----
`default_nettype none

module cpsp_out_buf
  import cpsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      has_space,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_data
);

  res_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign has_space = (count_r != 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= 2'(count_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> has_space)
    else $error("result written into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == 2'($past(count_r) + 2'd1))
    else $error("result buffer count did not advance on write");
`endif

endmodule

`default_nettype wire

// ----- design/constant_pool_section_parser_unit.sv -----
// Constant-pool section parser.
// Input channel (in_valid/in_ready): a request with in_opcode 0 starts a
// section of in_section_size bytes; a request with in_opcode 1 delivers the
// next section byte in in_data_byte.
// Result channel (out_valid/out_ready): at most one result per request,
// reporting a completed entry (tag, length, payload offset), the final
// status, or both at once. A start also aborts any section in progress.
// A request is held in the input register, and its decode runs from there
// straight into the result buffer, from which the result is offered.
// Throughput: one request per cycle while the result buffer has space, set by
// the combinational decode of one byte against the held counters; the
// two-entry result buffer lets a request be taken while one result still waits.
// Reset (rst_n low, synchronous) returns the parser to idle and empties
// both registers. When the receiver stalls, the buffer fills and in_ready
// drops; nothing is lost or repeated.
`default_nettype none

module constant_pool_section_parser_unit
  import cpsp_pkg::*;
#(
  parameter int unsigned NUM_TAGS = CPSP_NUM_TAGS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_section_size,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_entry_valid,
  output logic [31:0]      out_entry_number,
  output logic [7:0]       out_entry_tag,
  output logic [31:0]      out_entry_length,
  output logic [31:0]      out_payload_offset,
  output logic             out_final_res,
  output logic [1:0]       out_status
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     has_space;
  logic     step_en;
  logic     res_valid;
  res_t     res;
  res_t     out_data;

  assign in_item.opcode       = in_opcode;
  assign in_item.section_size = in_section_size;
  assign in_item.data_byte    = in_data_byte;

  assign step_en = item_valid && has_space;

  cpsp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (step_en),
    .item_valid (item_valid),
    .item       (item)
  );

  cpsp_core #(
    .NUM_TAGS (NUM_TAGS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  cpsp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .has_space (has_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_entry_valid    = out_data.entry_valid;
  assign out_entry_number   = out_data.entry_number;
  assign out_entry_tag      = out_data.entry_tag;
  assign out_entry_length   = out_data.entry_length;
  assign out_payload_offset = out_data.payload_offset;
  assign out_final_res      = out_data.final_res;
  assign out_status         = out_data.status;

endmodule

`default_nettype wire

// ----- test/constant_pool_section_checker.sv -----
`default_nettype none

module constant_pool_section_checker
  import cpsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        in_opcode,
  input  wire logic [31:0] in_section_size,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        out_entry_valid,
  input  wire logic [31:0] out_entry_number,
  input  wire logic [7:0]  out_entry_tag,
  input  wire logic [31:0] out_entry_length,
  input  wire logic [31:0] out_payload_offset,
  input  wire logic        out_final_res,
  input  wire logic [1:0]  out_status,
  output int               mismatch_count,
  output int               expected_left
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_HEADER, PH_LENGTH, PH_PAYLOAD, PH_PAD, PH_DONE
  } parse_phase_e;

  parse_phase_e sec_phase;
  logic [31:0]  consumed;
  logic [31:0]  sec_size;
  logic [31:0]  entries_todo;
  logic [31:0]  entry_idx;
  logic [31:0]  assembled;
  logic [1:0]   field_byte;
  logic [7:0]   held_tag;
  logic [31:0]  bytes_todo;
  logic [31:0]  payload_at;

  res_t expected_results[$];
  int   results_seen;

  function automatic void clear_parser();
    sec_phase    = PH_IDLE;
    consumed     = '0;
    sec_size     = '0;
    entries_todo = '0;
    entry_idx    = '0;
    assembled    = '0;
    field_byte   = '0;
    held_tag     = '0;
    bytes_todo   = '0;
    payload_at   = '0;
  endfunction

  function automatic res_t end_decode(input logic [1:0] st);
    res_t r;
    r           = '0;
    r.final_res = 1'b1;
    r.status    = st;
    sec_phase   = PH_DONE;
    return r;
  endfunction

  // Report the finished entry; close the section too when nothing more can follow.
  function automatic res_t close_entry();
    res_t r;
    r                = '0;
    r.entry_valid    = 1'b1;
    r.entry_number   = entry_idx;
    r.entry_tag      = held_tag;
    r.entry_length   = assembled;
    r.payload_offset = payload_at;
    if (entries_todo <= 32'd1) begin
      r.final_res = 1'b1;
    end else if (sec_size - consumed < 32'd4) begin
      r.final_res = 1'b1;
      r.status    = ST_TRUNC;
    end
    entry_idx++;
    entries_todo--;
    field_byte = '0;
    sec_phase  = r.final_res ? PH_DONE : PH_HEADER;
    return r;
  endfunction

  function automatic bit parse_request(input in_item_t req, output res_t res);
    logic [1:0]  k;
    logic [31:0] room;
    logic [31:0] pad;
    res = '0;
    if (req.opcode == OP_START) begin
      clear_parser();
      sec_size = req.section_size;
      if (sec_size < 32'd4) begin
        res = end_decode(ST_TRUNC);
        return 1'b1;
      end
      sec_phase = PH_COUNT;
      return 1'b0;
    end
    k = field_byte;
    case (sec_phase)
      PH_COUNT: begin
        assembled  |= {24'd0, req.data_byte} << {k, 3'b000};
        consumed++;
        field_byte = k + 2'd1;
        if (k != 2'd3) return 1'b0;
        if (assembled == 32'd0) begin
          res = end_decode(ST_OK);
          return 1'b1;
        end
        if (assembled > ((sec_size - 32'd4) >> CPSP_HDR_SHIFT)) begin
          res = end_decode(ST_TRUNC);
          return 1'b1;
        end
        entries_todo = assembled;
        assembled    = '0;
        sec_phase    = PH_HEADER;
        return 1'b0;
      end
      PH_HEADER: begin
        consumed++;
        field_byte = k + 2'd1;
        if (k == 2'd0) begin
          held_tag = req.data_byte;
          return 1'b0;
        end
        if (req.data_byte != 8'd0) begin
          res = end_decode(ST_RESERVED);
          return 1'b1;
        end
        if (k != 2'd3) return 1'b0;
        if (held_tag >= CPSP_NUM_TAGS_DEF) begin
          res = end_decode(ST_BADTAG);
          return 1'b1;
        end
        if (sec_size - consumed < 32'd4) begin
          res = end_decode(ST_TRUNC);
          return 1'b1;
        end
        assembled = '0;
        sec_phase = PH_LENGTH;
        return 1'b0;
      end
      PH_LENGTH: begin
        assembled  |= {24'd0, req.data_byte} << {k, 3'b000};
        consumed++;
        field_byte = k + 2'd1;
        if (k != 2'd3) return 1'b0;
        room = sec_size - consumed;
        // payload and its padding must both fit before the end of the section
        pad  = (32'd0 - (consumed + assembled)) & 32'd3;
        if (assembled > room || pad > room - assembled) begin
          res = end_decode(ST_TRUNC);
          return 1'b1;
        end
        payload_at = consumed;
        if (assembled == 32'd0) begin
          res = close_entry();
          return 1'b1;
        end
        bytes_todo = assembled;
        sec_phase  = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        consumed++;
        bytes_todo--;
        if (bytes_todo != 32'd0) return 1'b0;
        pad = (32'd0 - consumed) & 32'd3;
        if (pad == 32'd0) begin
          res = close_entry();
          return 1'b1;
        end
        bytes_todo = pad;
        sec_phase  = PH_PAD;
        return 1'b0;
      end
      PH_PAD: begin
        consumed++;
        if (req.data_byte != 8'd0) begin
          res = end_decode(ST_RESERVED);
          return 1'b1;
        end
        bytes_todo--;
        if (bytes_todo != 32'd0) return 1'b0;
        res = close_entry();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin : watch
    res_t     got;
    res_t     want;
    res_t     pred;
    in_item_t req;
    if (!rst_n) begin
      clear_parser();
      expected_results.delete();
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_entry_valid, out_entry_number, out_entry_tag, out_entry_length,
               out_payload_offset, out_final_res, out_status};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none outstanding",
                                    results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("entry_valid", 32'(got.entry_valid), 32'(want.entry_valid));
          check_field("entry_number", got.entry_number, want.entry_number);
          check_field("entry_tag", 32'(got.entry_tag), 32'(want.entry_tag));
          check_field("entry_length", got.entry_length, want.entry_length);
          check_field("payload_offset", got.payload_offset, want.payload_offset);
          check_field("final_res", 32'(got.final_res), 32'(want.final_res));
          check_field("status", 32'(got.status), 32'(want.status));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        req = {in_opcode, in_section_size, in_data_byte};
        if (parse_request(req, pred)) expected_results.push_back(pred);
      end
    end
    expected_left = expected_results.size();
  end

endmodule

`default_nettype wire

// ----- test/constant_pool_section_parser_unit_tb.sv -----
`default_nettype none

module constant_pool_section_parser_unit_tb;
  import cpsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    FLT_NONE, FLT_RESERVED, FLT_TAG, FLT_PAD, FLT_SHORT, FLT_COUNT, FLT_LENGTH
  } section_fault_e;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        in_opcode       = OP_BYTE;
  logic [31:0] in_section_size = '0;
  logic [7:0]  in_data_byte    = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic        out_entry_valid;
  logic [31:0] out_entry_number;
  logic [7:0]  out_entry_tag;
  logic [31:0] out_entry_length;
  logic [31:0] out_payload_offset;
  logic        out_final_res;
  logic [1:0]  out_status;

  int mismatch_count;
  int expected_left;

  int gap_pct   = 0;
  int stall_pct = 0;
  int sent      = 0;

  logic [7:0]  section_bytes[$];
  int unsigned tag_spots[$];
  int unsigned pad_spots[$];

  constant_pool_section_parser_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_section_size    (in_section_size),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_valid    (out_entry_valid),
    .out_entry_number   (out_entry_number),
    .out_entry_tag      (out_entry_tag),
    .out_entry_length   (out_entry_length),
    .out_payload_offset (out_payload_offset),
    .out_final_res      (out_final_res),
    .out_status         (out_status)
  );

  constant_pool_section_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_section_size    (in_section_size),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_valid    (out_entry_valid),
    .out_entry_number   (out_entry_number),
    .out_entry_tag      (out_entry_tag),
    .out_entry_length   (out_entry_length),
    .out_payload_offset (out_payload_offset),
    .out_final_res      (out_final_res),
    .out_status         (out_status),
    .mismatch_count     (mismatch_count),
    .expected_left      (expected_left)
  );

  always #5ns clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic op, input logic [31:0] size, input logic [7:0] data,
                          input bit counted);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    // fill the unused field with junk: the block must ignore it
    in_section_size <= (op == OP_START) ? size : $urandom();
    in_data_byte    <= (op == OP_BYTE) ? data : 8'($urandom());
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (counted) sent++;
  endtask

  task automatic send_section(input logic [31:0] size, input int upto);
    send_req(OP_START, size, 8'd0, 1'b1);
    for (int i = 0; i < upto && i < section_bytes.size(); i++)
      send_req(OP_BYTE, 32'd0, section_bytes[i], 1'b1);
  endtask

  // Lay out a well-formed section, then perhaps break one thing in it.
  task automatic compose_section(output logic [31:0] size_out);
    int             n;
    int             len;
    int unsigned    spot;
    logic [31:0]    count;
    section_fault_e fault;
    section_bytes.delete();
    tag_spots.delete();
    pad_spots.delete();
    n     = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
    count = n;
    repeat (4) section_bytes.push_back(8'd0);
    for (int e = 0; e < n; e++) begin
      tag_spots.push_back(section_bytes.size());
      section_bytes.push_back(8'($urandom_range(0, CPSP_NUM_TAGS_DEF - 1)));
      repeat (3) section_bytes.push_back(8'd0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
      for (int b = 0; b < 4; b++) section_bytes.push_back(8'(len >> (8 * b)));
      repeat (len) section_bytes.push_back(8'($urandom_range(0, 255)));
      while (section_bytes.size() % 4 != 0) begin
        pad_spots.push_back(section_bytes.size());
        section_bytes.push_back(8'd0);
      end
    end
    size_out = section_bytes.size();
    if ($urandom_range(0, 3) == 0) size_out += $urandom_range(1, 7);
    if ($urandom_range(0, 15) == 0) size_out |= $urandom() | 32'h8000_0000;
    fault = ($urandom_range(0, 15) < 6) ? section_fault_e'($urandom_range(1, 6)) : FLT_NONE;
    case (fault)
      FLT_RESERVED: begin
        if (tag_spots.size() != 0) begin
          spot = tag_spots[$urandom_range(0, tag_spots.size() - 1)] + $urandom_range(1, 3);
          section_bytes[spot] = 8'($urandom_range(1, 255));
        end
      end
      FLT_TAG: begin
        if (tag_spots.size() != 0) begin
          spot = tag_spots[$urandom_range(0, tag_spots.size() - 1)];
          section_bytes[spot] = 8'($urandom_range(CPSP_NUM_TAGS_DEF, 255));
        end
      end
      FLT_PAD: begin
        if (pad_spots.size() != 0) begin
          spot = pad_spots[$urandom_range(0, pad_spots.size() - 1)];
          section_bytes[spot] = 8'($urandom_range(1, 255));
        end
      end
      FLT_SHORT: begin
        size_out = section_bytes.size();
        size_out -= $urandom_range(1, (size_out < 8) ? size_out : 8);
      end
      FLT_COUNT: begin
        count = $urandom_range(0, 1) ? n + $urandom_range(1, 3) : $urandom();
      end
      FLT_LENGTH: begin
        if (tag_spots.size() != 0) begin
          spot = tag_spots[$urandom_range(0, tag_spots.size() - 1)] + 4 + $urandom_range(0, 3);
          section_bytes[spot] = 8'($urandom_range(1, 255));
        end
      end
      default: ;
    endcase
    for (int b = 0; b < 4; b++) section_bytes[b] = count[8 * b +: 8];
  endtask

  initial begin
    logic [31:0] size;
    int          upto;
    gap_pct   = 22;
    stall_pct = 82;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // byte while idle, short sections, zero count, oversized count
    send_req(OP_BYTE, 32'd0, 8'hFF, 1'b0);
    send_req(OP_START, 32'd3, 8'd0, 1'b1);
    section_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_section(32'd4, 4);
    section_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_section(32'd12, 4);
    // single empty entry with the top tag: entry report and end together
    section_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00};
    send_section(32'hFFFF_FFFF, 12);

    while (sent < 900) begin
      if (sent < 300) begin
        gap_pct   = 22;
        stall_pct = 82;
      end else if (sent < 600) begin
        gap_pct   = 82;
        stall_pct = 22;
      end else begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if ($urandom_range(0, 19) < 3) begin
        // noise: any size, then loose bytes
        case ($urandom_range(0, 2))
          0:       size = $urandom_range(0, 3);
          1:       size = $urandom();
          default: size = $urandom_range(4, 40);
        endcase
        section_bytes.delete();
        repeat ($urandom_range(0, 12)) section_bytes.push_back(8'($urandom()));
        send_section(size, section_bytes.size());
      end else begin
        compose_section(size);
        // cut some sections short so the next start aborts them
        upto = ($urandom_range(0, 9) == 0) ? $urandom_range(0, section_bytes.size())
                                           : section_bytes.size();
        send_section(size, upto);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_req(OP_BYTE, 32'd0, 8'($urandom()), 1'b0);
      end
    end
    in_valid <= 1'b0;

    while (expected_left != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("constant_pool_section_parser_unit_tb: clean");
    end else begin
      $display("constant_pool_section_parser_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("constant_pool_section_parser_unit_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/cpsp_pkg.sv
design/cpsp_in_stage.sv
design/cpsp_core.sv
design/cpsp_out_buf.sv
design/constant_pool_section_parser_unit.sv
test/constant_pool_section_checker.sv
test/constant_pool_section_parser_unit_tb.sv
